### rtl/scks_pkg.sv
// Package: shared widths, match characters and progress codes for the crib key search.
`timescale 1ns / 1ps

package scks_pkg;

    localparam int DEF_NUM_KEYS   = 255;
    localparam int DEF_COUNT_BITS = 24;

    localparam int BYTE_BITS      = 8;
    localparam int KEY_BITS       = 8;
    localparam int OUT_COUNT_BITS = 24;

    localparam logic [BYTE_BITS-1:0] CH_T = 8'h74;
    localparam logic [BYTE_BITS-1:0] CH_H = 8'h68;
    localparam logic [BYTE_BITS-1:0] CH_E = 8'h65;

    typedef logic [1:0] progress_t;

    localparam progress_t PROG_NONE = 2'd0;
    localparam progress_t PROG_T    = 2'd1;
    localparam progress_t PROG_TH   = 2'd2;

endpackage

### rtl/scks_cell.sv
// Key cell: word matcher and counter for one key, and one stage of the best-key sweep.
`timescale 1ns / 1ps

module scks_cell #(
    parameter int KEY        = 0,
    parameter int COUNT_BITS = scks_pkg::DEF_COUNT_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          update,
    input  logic [scks_pkg::BYTE_BITS-1:0] text_byte,
    input  logic                          wave_in_valid,
    input  logic [scks_pkg::KEY_BITS-1:0] wave_in_key,
    input  logic [COUNT_BITS-1:0]         wave_in_count,
    output logic                          wave_out_valid,
    output logic [scks_pkg::KEY_BITS-1:0] wave_out_key,
    output logic [COUNT_BITS-1:0]         wave_out_count
);
    import scks_pkg::*;

    localparam logic [KEY_BITS-1:0] KEY_VAL = KEY_BITS'(KEY);

    logic [BYTE_BITS-1:0]  decoded;
    progress_t             prog_reg;
    progress_t             prog_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  wave_valid_reg;
    logic [KEY_BITS-1:0]   wave_key_reg;
    logic [KEY_BITS-1:0]   wave_key_next;
    logic [COUNT_BITS-1:0] wave_count_reg;
    logic [COUNT_BITS-1:0] wave_count_next;

    assign decoded = text_byte - KEY_VAL;

    always_comb
    begin
        prog_next  = prog_reg;
        count_next = count_reg;
        if (wave_in_valid)
        begin
            prog_next  = PROG_NONE;
            count_next = '0;
        end
        else if (update)
        begin
            if (prog_reg == PROG_TH && decoded == CH_E)
            begin
                if (count_reg != '1)
                begin
                    count_next = count_reg + COUNT_BITS'(1);
                end
                prog_next = PROG_NONE;
            end
            else if (decoded == CH_T)
            begin
                prog_next = PROG_T;
            end
            else if (prog_reg == PROG_T && decoded == CH_H)
            begin
                prog_next = PROG_TH;
            end
            else
            begin
                prog_next = PROG_NONE;
            end
        end
    end

    always_comb
    begin
        if (count_reg > wave_in_count)
        begin
            wave_key_next   = KEY_VAL;
            wave_count_next = count_reg;
        end
        else
        begin
            wave_key_next   = wave_in_key;
            wave_count_next = wave_in_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prog_reg       <= PROG_NONE;
            count_reg      <= '0;
            wave_valid_reg <= 1'b0;
        end
        else
        begin
            prog_reg       <= prog_next;
            count_reg      <= count_next;
            wave_valid_reg <= wave_in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        wave_key_reg   <= wave_key_next;
        wave_count_reg <= wave_count_next;
    end

    assign wave_out_valid = wave_valid_reg;
    assign wave_out_key   = wave_key_reg;
    assign wave_out_count = wave_count_reg;

endmodule

### rtl/shift_cipher_crib_key_search_unit.sv
// Top level: shift-cipher key search over a row of key cells with a swept best-key result.
//
//  channel | dir | word                                    | sideband
//  s_      | in  | tdata[7:0] text_byte                    | tlast end_of_text
//  m_      | out | tdata[7:0] best_key, [31:8] best_count  | tuser[0] key_found
//
// One word per cycle while s_tready is high; every key cell updates on each accepted word.
// After the word with tlast, a sweep passes cell to cell, one cell a cycle: the result
// is registered after the last cell, and the cells are cleared as the sweep passes.
// s_tready is low during the sweep, and for a tlast word while a result still waits.
// Reset clears all progress, counts and the result valid flag.
`timescale 1ns / 1ps

module shift_cipher_crib_key_search_unit #(
    parameter int NUM_KEYS   = scks_pkg::DEF_NUM_KEYS,
    parameter int COUNT_BITS = scks_pkg::DEF_COUNT_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] best_key, [31:8] best_count
    output logic [0:0]  m_tuser    // [0] key_found
);
    import scks_pkg::*;

    logic                      accept;
    logic                      busy_reg;
    logic                      start_reg;
    logic [NUM_KEYS:0]         wave_valid;
    logic [KEY_BITS-1:0]       wave_key   [NUM_KEYS+1];
    logic [COUNT_BITS-1:0]     wave_count [NUM_KEYS+1];
    logic [OUT_COUNT_BITS-1:0] count_field;
    logic                      out_valid_reg;
    logic [KEY_BITS-1:0]       out_key_reg;
    logic [OUT_COUNT_BITS-1:0] out_count_reg;
    logic                      out_found_reg;

    assign s_tready = !busy_reg && !(out_valid_reg && s_tlast);
    assign accept   = s_tvalid && s_tready;

    assign wave_valid[0] = start_reg;
    assign wave_key[0]   = '0;
    assign wave_count[0] = '0;

    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_cell
        scks_cell #(
            .KEY        (k),
            .COUNT_BITS (COUNT_BITS)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .update         (accept),
            .text_byte      (s_tdata),
            .wave_in_valid  (wave_valid[k]),
            .wave_in_key    (wave_key[k]),
            .wave_in_count  (wave_count[k]),
            .wave_out_valid (wave_valid[k+1]),
            .wave_out_key   (wave_key[k+1]),
            .wave_out_count (wave_count[k+1])
        );
    end

    if (COUNT_BITS >= OUT_COUNT_BITS)
    begin : g_trunc
        assign count_field = wave_count[NUM_KEYS][OUT_COUNT_BITS-1:0];
    end
    else
    begin : g_ext
        assign count_field = {{(OUT_COUNT_BITS-COUNT_BITS){1'b0}}, wave_count[NUM_KEYS]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            start_reg <= accept && s_tlast;
            if (accept && s_tlast)
            begin
                busy_reg <= 1'b1;
            end
            else if (wave_valid[NUM_KEYS])
            begin
                busy_reg <= 1'b0;
            end
            if (wave_valid[NUM_KEYS])
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wave_valid[NUM_KEYS])
        begin
            out_key_reg   <= wave_key[NUM_KEYS];
            out_count_reg <= count_field;
            out_found_reg <= (wave_count[NUM_KEYS] != '0);
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {out_count_reg, out_key_reg};
    assign m_tuser[0] = out_found_reg;

endmodule

### rtl/scks_checker.sv
// Checker: port-level properties of the crib key search, bound to the top level.
`timescale 1ns / 1ps

module scks_checker #(
    parameter int NUM_KEYS = scks_pkg::DEF_NUM_KEYS
) (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [0:0]  m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready && !m_tvalid)
        else $error("input taken or result shown right after final word");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == 32'd0)
        else $error("nonzero result without a scoring key");

    a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> int'(m_tdata[7:0]) < NUM_KEYS)
        else $error("best key out of range");

endmodule

bind shift_cipher_crib_key_search_unit scks_checker #(.NUM_KEYS(NUM_KEYS)) u_scks_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
